[src/assert_macros.svh]
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication check under synchronous reset.
`define ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);
// Invariant check under synchronous reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`endif

[src/lbs_pkg.sv]
//------------------------------------------------------------------------------
// lbs_pkg
// Types and constants for the skinning engine.
//------------------------------------------------------------------------------
`default_nettype none
package lbs_pkg;
  localparam int BoneCountDefault    = 64;
  localparam int FractionBitsDefault = 16;
  localparam int WordsPerBone        = 12;
  localparam int WordW               = 32;
  localparam int WeightW             = 17;
  localparam int AccW                = 64;

  typedef enum logic {CMD_WRITE = 1'b0, CMD_SKIN = 1'b1} cmd_t;

  typedef enum logic [1:0] {BK_IDLE, BK_RUN, BK_ACC, BK_OUT} bk_state_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [WordW-1:0] sat32(input logic signed [AccW-1:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[WordW-1:0];
  endfunction
endpackage
`default_nettype wire

[src/lbs_ram.sv]
//------------------------------------------------------------------------------
// lbs_ram
// Generic single-port-write, single-port-read RAM with registered read.
//------------------------------------------------------------------------------
`default_nettype none
module lbs_ram #(
  parameter int Width = 32,
  parameter int Depth = 768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/lbs_queue.sv]
//------------------------------------------------------------------------------
// lbs_queue
// Two-entry queue of classified influences between front and back.
//------------------------------------------------------------------------------
`default_nettype none
module lbs_queue #(
  parameter int Width = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [Width-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [Width-1:0] out_data
);
  `include "assert_macros.svh"
  logic [Width-1:0] slots [2];
  logic             rd_ptr, wr_ptr;
  logic [1:0]       count;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) slots[wr_ptr] <= in_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (out_valid && out_ready) rd_ptr <= ~rd_ptr;
      count <= count + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  `ASSERT_ALWAYS(a_count_range, clk, rst, count != 2'd3, "queue count out of range")
  `ASSERT_IMP(a_full_ptrs, clk, rst, count == 2'd2, rd_ptr == wr_ptr, "full queue ptr mismatch")
  `ASSERT_IMP(a_empty_ptrs, clk, rst, count == 2'd0, rd_ptr == wr_ptr, "empty queue ptr mismatch")
endmodule
`default_nettype wire

[src/lbs_front.sv]
//------------------------------------------------------------------------------
// lbs_front
// Accepts transactions, writes palette words, forwards influences.
//------------------------------------------------------------------------------
`default_nettype none
module lbs_front #(
  parameter int BoneCount = lbs_pkg::BoneCountDefault,
  parameter int QW        = 8,
  parameter int AddrW     = 10
) (
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     command,
  input  wire logic [5:0]               bone_index,
  input  wire logic [3:0]               matrix_element,
  input  wire logic [31:0]              matrix_value,
  input  wire logic [QW-1:0]            infl_data,
  input  wire logic                     busy,
  output logic                          q_valid,
  input  wire logic                     q_ready,
  output logic      [QW-1:0]            q_data,
  output logic                          pal_we,
  output logic      [AddrW-1:0]         pal_waddr,
  output logic      [31:0]              pal_wdata
);
  import lbs_pkg::*;
  logic is_skin;

  // influences need queue room; writes wait until no queued influence
  // still has palette words to read
  assign is_skin   = command == CMD_SKIN;
  assign in_ready  = is_skin ? q_ready : !busy;
  assign q_valid   = in_valid && is_skin;
  assign q_data    = infl_data;
  assign pal_we    = in_valid && !is_skin && !busy && (32'(bone_index) < BoneCount)
                     && (matrix_element < 4'(WordsPerBone));
  assign pal_waddr = AddrW'(32'(bone_index) * WordsPerBone + 32'(matrix_element));
  assign pal_wdata = matrix_value;
endmodule
`default_nettype wire

[src/lbs_back.sv]
//------------------------------------------------------------------------------
// lbs_back
// Sequential transform: one palette word per cycle into shared position and normal MACs.
//------------------------------------------------------------------------------
`default_nettype none
module lbs_back #(
  parameter int BoneCount    = lbs_pkg::BoneCountDefault,
  parameter int FractionBits = lbs_pkg::FractionBitsDefault,
  parameter int QW           = 8,
  parameter int AddrW        = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire logic [QW-1:0]     q_data,
  output logic                   rd_busy,
  output logic      [AddrW-1:0]  pal_raddr,
  input  wire logic [31:0]       pal_rdata,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [31:0]       skinned_x,
  output logic      [31:0]       skinned_y,
  output logic      [31:0]       skinned_z,
  output logic      [31:0]       skinned_nx,
  output logic      [31:0]       skinned_ny,
  output logic      [31:0]       skinned_nz
);
  import lbs_pkg::*;
  `include "assert_macros.svh"

  // held influence
  logic [5:0]               bone;
  logic signed [31:0]       p [3];
  logic signed [31:0]       n [3];
  logic [WeightW-1:0]       w;
  logic                     last;
  logic                     bone_ok;
  bk_state_t                state, state_next;
  logic [3:0]               rcnt;     // read address index
  logic [3:0]               word;     // index of word arriving this cycle
  logic                     word_v;
  logic signed [AccW-1:0]   tp [3];
  logic signed [AccW-1:0]   tn [3];
  logic signed [AccW-1:0]   pacc [3];
  logic signed [AccW-1:0]   nacc [3];
  logic [1:0]               col;
  logic signed [31:0]       m;
  logic [1:0]               rr, cc;
  logic signed [63:0]       prod_p, prod_n;
  logic signed [31:0]       sp, sn;
  logic signed [63:0]       wp, wn;

  // row and column of a row-major palette word; translation words use row 0,
  // their product is not used
  function automatic logic [3:0] word_pos(input logic [3:0] wd);
    case (wd)
      4'd0:  return {2'd0, 2'd0};
      4'd1:  return {2'd0, 2'd1};
      4'd2:  return {2'd0, 2'd2};
      4'd3:  return {2'd1, 2'd0};
      4'd4:  return {2'd1, 2'd1};
      4'd5:  return {2'd1, 2'd2};
      4'd6:  return {2'd2, 2'd0};
      4'd7:  return {2'd2, 2'd1};
      4'd8:  return {2'd2, 2'd2};
      4'd9:  return {2'd0, 2'd0};
      4'd10: return {2'd0, 2'd1};
      4'd11: return {2'd0, 2'd2};
      default: return {2'd0, 2'd0};
    endcase
  endfunction

  assign q_ready   = state == BK_IDLE;
  assign rd_busy   = state == BK_RUN;
  assign pal_raddr = AddrW'(32'(bone) * WordsPerBone + 32'(rcnt));
  assign m         = bone_ok ? $signed(pal_rdata) : 32'sd0;
  assign {rr, cc}  = word_pos(word);
  assign prod_p    = 64'(p[rr]) * 64'(m);
  assign prod_n    = 64'(n[rr]) * 64'(m);

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (q_valid && q_ready) state_next = BK_RUN;
      BK_RUN:  if (word_v && word == 4'(WordsPerBone-1)) state_next = BK_ACC;
      BK_ACC:  if (col == 2'd2) state_next = last ? BK_OUT : BK_IDLE;
      BK_OUT:  if (!out_valid || out_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  assign sp = sat32(tp[col]);
  assign sn = sat32(tn[col]);
  assign wp = 64'(sp) * $signed({47'd0, w});
  assign wn = 64'(sn) * $signed({47'd0, w});

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      word_v    <= 1'b0;
      rcnt      <= '0;
      col       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pacc[i] <= '0;
        nacc[i] <= '0;
      end
    end else begin
      // result register: load when free, drop on acceptance
      if (state == BK_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        BK_IDLE: begin
          if (q_valid && q_ready) begin
            {bone, p[0], p[1], p[2], n[0], n[1], n[2], w, last} <= q_data;
            bone_ok <= 32'(q_data[QW-1 -: 6]) < BoneCount;
            rcnt    <= '0;
            word_v  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              tp[i] <= '0;
              tn[i] <= '0;
            end
          end
        end
        BK_RUN: begin
          word_v <= rcnt < 4'(WordsPerBone);
          word   <= rcnt;
          if (rcnt < 4'(WordsPerBone)) rcnt <= rcnt + 4'd1;
          if (word_v) begin
            if (word >= 4'd9) tp[cc] <= tp[cc] + 64'(m);
            else begin
              tp[cc] <= tp[cc] + (prod_p >>> FractionBits);
              tn[cc] <= tn[cc] + (prod_n >>> FractionBits);
            end
          end
          col <= '0;
        end
        BK_ACC: begin
          pacc[col] <= pacc[col] + (wp >>> FractionBits);
          nacc[col] <= nacc[col] + (wn >>> FractionBits);
          col <= col + 2'd1;
        end
        BK_OUT: begin
          if (!out_valid || out_ready) begin
            skinned_x  <= sat32(pacc[0]);
            skinned_y  <= sat32(pacc[1]);
            skinned_z  <= sat32(pacc[2]);
            skinned_nx <= sat32(nacc[0]);
            skinned_ny <= sat32(nacc[1]);
            skinned_nz <= sat32(nacc[2]);
            for (int i = 0; i < 3; i++) begin
              pacc[i] <= '0;
              nacc[i] <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMP(a_take_idle, clk, rst, q_valid && q_ready, state == BK_IDLE, "take outside idle")
  `ASSERT_IMP(a_rcnt, clk, rst, state == BK_RUN, rcnt <= 4'(WordsPerBone), "read index overrun")
  `ASSERT_IMP(a_acc_col, clk, rst, state == BK_ACC, col != 2'd3, "column overrun")
endmodule
`default_nettype wire

[src/linear_blend_skinning.sv]
// An influence leaves the queue, its 12 palette words are read through one
// registered read port, three weighted accumulates follow, and on a last
// influence the result register is loaded. The back end takes one influence
// at a time, the queue holding up to two more; the next is taken while a
// result waits. A palette write is accepted once no read is pending.
// Reset (rst, synchronous) clears control and accumulators, not the palette.
`default_nettype none
module linear_blend_skinning #(
  parameter int BONE_COUNT    = lbs_pkg::BoneCountDefault,
  parameter int FRACTION_BITS = lbs_pkg::FractionBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [5:0]  bone_index,
  input  wire logic [3:0]  matrix_element,
  input  wire logic [31:0] matrix_value,
  input  wire logic [31:0] pos_x,
  input  wire logic [31:0] pos_y,
  input  wire logic [31:0] pos_z,
  input  wire logic [31:0] norm_x,
  input  wire logic [31:0] norm_y,
  input  wire logic [31:0] norm_z,
  input  wire logic [16:0] blend_weight,
  input  wire logic        last_influence,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      skinned_x,
  output logic [31:0]      skinned_y,
  output logic [31:0]      skinned_z,
  output logic [31:0]      skinned_nx,
  output logic [31:0]      skinned_ny,
  output logic [31:0]      skinned_nz
);
  import lbs_pkg::*;
  localparam int Depth = BONE_COUNT * WordsPerBone;
  localparam int AddrW = $clog2(Depth);
  localparam int QW    = 6 + 6*32 + WeightW + 1;

  logic [QW-1:0]    infl, qd_in, qd_out;
  logic             fq_valid, fq_ready, bq_valid, bq_ready;
  logic             pal_we;
  logic [AddrW-1:0] pal_waddr, pal_raddr;
  logic [31:0]      pal_wdata, pal_rdata;
  logic             back_busy, pal_busy;

  assign infl = {bone_index, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                 blend_weight, last_influence};

  // palette writes hold off while any influence still has words to read
  assign pal_busy = bq_valid || back_busy;

  lbs_front #(.BoneCount(BONE_COUNT), .QW(QW), .AddrW(AddrW)) u_front (
    .in_valid, .in_ready, .command, .bone_index, .matrix_element,
    .matrix_value, .infl_data(infl), .busy(pal_busy), .q_valid(fq_valid),
    .q_ready(fq_ready), .q_data(qd_in), .pal_we, .pal_waddr, .pal_wdata);

  lbs_queue #(.Width(QW)) u_queue (
    .clk, .rst, .in_valid(fq_valid), .in_ready(fq_ready), .in_data(qd_in),
    .out_valid(bq_valid), .out_ready(bq_ready), .out_data(qd_out));

  lbs_ram #(.Width(32), .Depth(Depth)) u_palette (
    .clk, .we(pal_we), .waddr(pal_waddr), .wdata(pal_wdata),
    .raddr(pal_raddr), .rdata(pal_rdata));

  lbs_back #(.BoneCount(BONE_COUNT), .FractionBits(FRACTION_BITS), .QW(QW),
             .AddrW(AddrW)) u_back (
    .clk, .rst, .q_valid(bq_valid), .q_ready(bq_ready), .q_data(qd_out),
    .rd_busy(back_busy), .pal_raddr, .pal_rdata, .out_valid, .out_ready,
    .skinned_x, .skinned_y, .skinned_z, .skinned_nx, .skinned_ny, .skinned_nz);
endmodule
`default_nettype wire

[bench/testbench.sv]
//------------------------------------------------------------------------------
// Skinning engine testbench
// Loads bone matrices into the palette, streams vertex influences, and checks
// each blended position and normal against a fixed-point predictor kept here.
//------------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lbs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = CMD_WRITE;
  logic [5:0] bone_index = '0;
  logic [3:0] matrix_element = '0;
  logic [31:0] matrix_value = '0;
  logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [31:0] norm_x = '0, norm_y = '0, norm_z = '0;
  logic [16:0] blend_weight = '0;
  logic last_influence = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] skinned_x, skinned_y, skinned_z;
  logic [31:0] skinned_nx, skinned_ny, skinned_nz;

  typedef struct packed {
    logic [31:0] x, y, z, nx, ny, nz;
  } vertex_t;

  // Predictor state
  logic signed [31:0] palette [64*WordsPerBone];
  bit palette_set [64];
  logic [63:0] pos_sum [3];
  logic [63:0] norm_sum [3];
  vertex_t vertex_q [$];
  int errors = 0;
  bit stall_out = 1'b0;
  bit no_gap = 1'b0;

  linear_blend_skinning dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Update the predictor with one transaction; push a vertex on a last influence.
  task automatic predict_transaction(logic cmd, logic [5:0] bone, logic [3:0] elem,
      logic [31:0] mval, logic [31:0] p [3], logic [31:0] n [3],
      logic [16:0] w, logic last);
    logic signed [63:0] tp, tn, m, wt;
    vertex_t v;
    if (cmd == CMD_WRITE) begin
      if (elem < WordsPerBone) palette[bone*WordsPerBone + elem] = mval;
      return;
    end
    for (int c = 0; c < 3; c++) begin
      tp = 64'(palette[bone*WordsPerBone + 9 + c]);
      tn = 0;
      for (int r = 0; r < 3; r++) begin
        m = 64'(palette[bone*WordsPerBone + r*3 + c]);
        tp += (64'(signed'(p[r])) * m) >>> 16;
        tn += (64'(signed'(n[r])) * m) >>> 16;
      end
      wt = (clamp32(tp) * $signed({47'd0, w})) >>> 16;
      pos_sum[c] += wt;
      wt = (clamp32(tn) * $signed({47'd0, w})) >>> 16;
      norm_sum[c] += wt;
    end
    if (!last) return;
    v.x = 32'(clamp32(pos_sum[0]));
    v.y = 32'(clamp32(pos_sum[1]));
    v.z = 32'(clamp32(pos_sum[2]));
    v.nx = 32'(clamp32(norm_sum[0]));
    v.ny = 32'(clamp32(norm_sum[1]));
    v.nz = 32'(clamp32(norm_sum[2]));
    vertex_q.push_back(v);
    for (int c = 0; c < 3; c++) begin
      pos_sum[c] = 0;
      norm_sum[c] = 0;
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one transaction and wait for its acceptance; valid drops only in a gap.
  task automatic send_transaction(logic cmd, logic [5:0] bone, logic [3:0] elem,
      logic [31:0] mval, logic [31:0] p [3], logic [31:0] n [3],
      logic [16:0] w, logic last);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    command <= cmd; bone_index <= bone; matrix_element <= elem; matrix_value <= mval;
    pos_x <= p[0]; pos_y <= p[1]; pos_z <= p[2];
    norm_x <= n[0]; norm_y <= n[1]; norm_z <= n[2];
    blend_weight <= w; last_influence <= last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_transaction(cmd, bone, elem, mval, p, n, w, last);
    if (cmd == CMD_WRITE && elem < WordsPerBone) palette_set[bone] = 1'b1;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 262143)) - 131072);
      default: return $urandom;
    endcase
  endfunction

  task automatic write_bone(logic [5:0] bone, bit identity);
    logic [31:0] z [3];
    logic [31:0] mv;
    z = '{0, 0, 0};
    for (int e = 0; e < WordsPerBone; e++) begin
      if (identity) mv = (e == 0 || e == 4 || e == 8) ? 32'h10000 : 32'h0;
      else mv = rand_word();
      send_transaction(CMD_WRITE, bone, 4'(e), mv, z, z, 17'($urandom), 1'($urandom));
    end
  endtask

  task automatic send_influence(logic [5:0] bone, logic [16:0] w, logic last);
    logic [31:0] p [3], n [3];
    for (int i = 0; i < 3; i++) begin
      p[i] = rand_word();
      n[i] = rand_word();
    end
    send_transaction(CMD_SKIN, bone, 4'($urandom), rand_word(), p, n, w, last);
  endtask

  function automatic logic [5:0] loaded_bone();
    logic [5:0] b;
    do b = 6'($urandom); while (!palette_set[b]);
    return b;
  endfunction

  // Result checker with random back-pressure.
  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    vertex_t want;
    if (!rst && out_valid && out_ready) begin
      if (vertex_q.size() == 0) begin
        report_mismatch("unexpected result transaction", skinned_x, 32'd0);
      end else begin
        want = vertex_q.pop_front();
        if (skinned_x !== want.x) report_mismatch("x", skinned_x, want.x);
        if (skinned_y !== want.y) report_mismatch("y", skinned_y, want.y);
        if (skinned_z !== want.z) report_mismatch("z", skinned_z, want.z);
        if (skinned_nx !== want.nx) report_mismatch("nx", skinned_nx, want.nx);
        if (skinned_ny !== want.ny) report_mismatch("ny", skinned_ny, want.ny);
        if (skinned_nz !== want.nz) report_mismatch("nz", skinned_nz, want.nz);
      end
    end
    if (stall_out) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) < 70) ? 1'b1 : ($urandom_range(0, 9) == 0);
  end

  // Fully loaded bones at the index extremes and bone 17, plus ignored writes.
  task automatic test_palette_load();
    logic [31:0] z [3];
    z = '{0, 0, 0};
    write_bone(6'd0, 1'b1);
    write_bone(6'd63, 1'b0);
    write_bone(6'd17, 1'b0);
    send_transaction(CMD_WRITE, 6'd5, 4'd12, 32'hdeadbeef, z, z, 17'd0, 1'b1);
    send_transaction(CMD_WRITE, 6'd5, 4'd15, 32'h12345678, z, z, 17'd0, 1'b0);
  endtask

  // Extremes: identity pass-through, full-scale weights, saturation.
  task automatic test_directed_influences();
    logic [31:0] p [3], n [3];
    p = '{32'h7fffffff, 32'h80000000, 32'h0};
    n = '{32'h80000000, 32'h7fffffff, 32'hffffffff};
    send_transaction(CMD_SKIN, 6'd0, 4'd0, 32'd0, p, n, 17'h10000, 1'b1);
    send_transaction(CMD_SKIN, 6'd63, 4'd0, 32'd0, p, n, 17'h1ffff, 1'b0);
    send_transaction(CMD_SKIN, 6'd63, 4'd0, 32'd0, p, n, 17'h1ffff, 1'b0);
    send_transaction(CMD_SKIN, 6'd17, 4'd0, 32'd0, n, p, 17'h1ffff, 1'b1);
    send_transaction(CMD_SKIN, 6'd0, 4'd0, 32'd0, p, n, 17'd0, 1'b1);
    send_influence(6'd17, 17'h08000, 1'b0);
    send_influence(6'd0, 17'h08000, 1'b1);
  endtask

  // Random vertices of 1..4 influences mixed with palette rewrites.
  task automatic test_random_vertices();
    int count, k;
    count = 0;
    while (count < 340) begin
      if ($urandom_range(0, 19) == 0) begin
        write_bone(6'($urandom), $urandom_range(0, 1));
        count += WordsPerBone;
      end else begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++)
          send_influence(loaded_bone(), ($urandom_range(0, 9) == 0) ? 17'($urandom)
                         : 17'($urandom_range(0, 65536)), i == k - 1);
        count += k;
      end
    end
  endtask

  // Stretch with the receiver always ready and no sender gaps.
  task automatic test_streaming();
    stall_out = 1'b1;
    no_gap = 1'b1;
    for (int i = 0; i < 20; i++)
      send_transaction(CMD_SKIN, loaded_bone(), 4'd0, 32'd0,
                       '{$urandom, $urandom, $urandom},
                       '{$urandom, $urandom, $urandom}, 17'($urandom), 1'($urandom));
    send_influence(6'd0, 17'h10000, 1'b1);
    no_gap = 1'b0;
    stall_out = 1'b0;
  endtask

  initial begin
    for (int c = 0; c < 3; c++) begin
      pos_sum[c] = 0;
      norm_sum[c] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_palette_load();
    test_directed_influences();
    test_random_vertices();
    test_streaming();
    in_valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
